@@ hdl/rmvd_pkg.sv @@
package rmvd_pkg;

   localparam int RING_DEPTH  = 256;
   localparam int AVERAGE_MAX = 64;
   localparam int SAMPLE_BITS = 8;

   // register field widths
   localparam int RL_W   = 9;
   localparam int AL_W   = 7;
   localparam int IL_W   = 9;
   localparam int THR_W  = 16;
   localparam int MIN_W  = 8;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam int IDX_W   = $clog2(RING_DEPTH);
   localparam int LEN_W   = $clog2(RING_DEPTH + 1);
   localparam int CNT_MAX = (RING_DEPTH > AVERAGE_MAX) ? RING_DEPTH : AVERAGE_MAX;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int DVS_W   = $clog2(AVERAGE_MAX + 1);
   localparam int ACC_W   = SAMPLE_BITS + $clog2(AVERAGE_MAX);
   localparam int DIFF_W  = ACC_W + 1;
   localparam int CMP_W   = (SAMPLE_BITS > MIN_W) ? SAMPLE_BITS : MIN_W;
   localparam int STEP_W  = $clog2(ACC_W + 1);

   localparam int DEV_W   = 16;
   localparam int LEVEL_W = 24;
   localparam logic [DEV_W-1:0]   DEV_MAX   = 16'hFFFF;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFFFFFF;

   typedef enum logic [2:0] {
      REG_RING_LENGTH,
      REG_AVERAGE_LENGTH,
      REG_INTEGRATE_LENGTH,
      REG_ALARM_THRESHOLD,
      REG_THRESHOLD_ENABLE,
      REG_SMOOTHING_ENABLE,
      REG_RSSI_FLOOR
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_VALID,
      ST_BOOTING,
      ST_TOO_LOW
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MEAN,
      S_DIV,
      S_SQR,
      S_SUM,
      S_FINISH,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [RL_W-1:0]         ring_length;
      logic [AL_W-1:0]         average_length;
      logic [IL_W-1:0]         integrate_length;
      logic [THR_W-1:0]        alarm_threshold;
      logic                    threshold_enable;
      logic                    smoothing_enable;
      logic signed [MIN_W-1:0] rssi_floor;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] dividend;
      logic [DVS_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] quotient;
   } div_rsp_type;

   // zero acts as one, oversize saturates
   function automatic int clamp_len(int v, int hi);
      if (v == 0) begin
         return 1;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

endpackage

@@ hdl/rssi_moving_variance_detector.sv @@
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_rssi_sample[7:0] signed
// rsp       out        rsp_valid / rsp_stall   rsp_status[1:0], rsp_level[23:0]
// csr       in/out     psel, penable, pwrite   paddr[4:0], pwdata, prdata, pready
//
// A rejected or booting item goes from the idle state straight to the emit state; a full
// item passes the mean, divide, square, sum and finish states, with one read a cycle from
// each ring memory and the 14-step serial divide. The input frees as the result turns valid.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous reset; the deviation ring has per-entry valid flags cleared at once,
// so there is no clearing pass. Writing ring_length restarts the rings.
module rssi_moving_variance_detector (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rmvd_pkg::SAMPLE_BITS-1:0] req_rssi_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [rmvd_pkg::LEVEL_W-1:0]     rsp_level,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rmvd_pkg::ADDR_W-1:0]      paddr,
   input  logic [rmvd_pkg::DATA_W-1:0]      pwdata,
   output logic [rmvd_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);
   import rmvd_pkg::*;

   cfg_type     cfg;
   logic        restart;
   div_req_type div_req;
   div_rsp_type div_rsp;

   rmvd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .restart (restart)
   );

   rmvd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rmvd_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .restart         (restart),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rssi_sample (req_rssi_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_level       (rsp_level),
      .div_req         (div_req),
      .div_rsp         (div_rsp)
   );

endmodule

@@ hdl/rmvd_csr.sv @@
module rmvd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rmvd_pkg::ADDR_W-1:0]  paddr,
   input  logic [rmvd_pkg::DATA_W-1:0]  pwdata,
   output logic [rmvd_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output rmvd_pkg::cfg_type            cfg,
   output logic                         restart
);
   import rmvd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (wr_en) begin
         unique case (idx)
            REG_RING_LENGTH: begin
               cfg_in.ring_length = pwdata[RL_W-1:0];
               restart            = 1'b1;
            end
            REG_AVERAGE_LENGTH:   cfg_in.average_length   = pwdata[AL_W-1:0];
            REG_INTEGRATE_LENGTH: cfg_in.integrate_length = pwdata[IL_W-1:0];
            REG_ALARM_THRESHOLD:  cfg_in.alarm_threshold  = pwdata[THR_W-1:0];
            REG_THRESHOLD_ENABLE: cfg_in.threshold_enable = pwdata[0];
            REG_SMOOTHING_ENABLE: cfg_in.smoothing_enable = pwdata[0];
            REG_RSSI_FLOOR:       cfg_in.rssi_floor       = pwdata[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_RING_LENGTH:      prdata = DATA_W'(cfg_ff.ring_length);
         REG_AVERAGE_LENGTH:   prdata = DATA_W'(cfg_ff.average_length);
         REG_INTEGRATE_LENGTH: prdata = DATA_W'(cfg_ff.integrate_length);
         REG_ALARM_THRESHOLD:  prdata = DATA_W'(cfg_ff.alarm_threshold);
         REG_THRESHOLD_ENABLE: prdata = DATA_W'(cfg_ff.threshold_enable);
         REG_SMOOTHING_ENABLE: prdata = DATA_W'(cfg_ff.smoothing_enable);
         REG_RSSI_FLOOR:       prdata = {{(DATA_W-MIN_W){1'b0}}, cfg_ff.rssi_floor};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_length      <= RL_W'(256);
         cfg_ff.average_length   <= AL_W'(64);
         cfg_ff.integrate_length <= IL_W'(3);
         cfg_ff.alarm_threshold  <= THR_W'(3);
         cfg_ff.threshold_enable <= 1'b0;
         cfg_ff.smoothing_enable <= 1'b0;
         cfg_ff.rssi_floor       <= 8'h9C;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/rmvd_div.sv @@
module rmvd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rmvd_pkg::div_req_type req,
   output rmvd_pkg::div_rsp_type rsp
);
   import rmvd_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic                    neg_ff;
   logic [STEP_W-1:0]       cnt_ff;
   logic [ACC_W-1:0]        work_ff;
   logic [DVS_W-1:0]        rem_ff;
   logic [DVS_W-1:0]        dvs_ff;
   logic signed [ACC_W-1:0] quot_ff;

   logic [DVS_W:0]          trial;
   logic [DVS_W:0]          diff;
   logic                    ge;
   logic [DVS_W-1:0]        rem_in;
   logic [ACC_W-1:0]        work_in;
   logic [ACC_W-1:0]        mag;

   assign mag = req.dividend[ACC_W-1] ? ACC_W'(-req.dividend) : ACC_W'(req.dividend);

   // one restoring step a cycle, quotient bits shift in behind the dividend
   always_comb begin
      trial   = {rem_ff, work_ff[ACC_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      work_in = {work_ff[ACC_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_W'(ACC_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         neg_ff  <= req.dividend[ACC_W-1];
         work_ff <= mag;
         rem_ff  <= '0;
         dvs_ff  <= req.divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
         if (cnt_ff == STEP_W'(1)) begin
            quot_ff <= neg_ff ? -$signed(work_in) : $signed(work_in);
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

@@ hdl/rmvd_core.sv @@
module rmvd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  rmvd_pkg::cfg_type                cfg,
   input  logic                             restart,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rmvd_pkg::SAMPLE_BITS-1:0] req_rssi_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [rmvd_pkg::LEVEL_W-1:0]     rsp_level,
   output rmvd_pkg::div_req_type            div_req,
   input  rmvd_pkg::div_rsp_type            div_rsp
);
   import rmvd_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic signed [SAMPLE_BITS-1:0] sample_mem [RING_DEPTH];
   logic [DEV_W-1:0]              dev_mem [RING_DEPTH];
   logic signed [SAMPLE_BITS-1:0] sample_q_ff;
   logic [DEV_W-1:0]              dev_q_ff;
   logic                          dev_q_vld_ff;
   logic [RING_DEPTH-1:0]         dev_vld_ff;

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [IDX_W-1:0]              swi_ff;
   logic [IDX_W-1:0]              dwi_ff;
   logic                          filled_ff;
   logic [LEVEL_W-1:0]            smooth_ff;
   logic [IDX_W-1:0]              ptr_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          rdv_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic [LEVEL_W-1:0]            sum_ff;
   status_type                    res_status_ff;
   logic [LEVEL_W-1:0]            res_level_ff;
   logic                          rsp_valid_ff;
   status_type                    rsp_status_ff;
   logic [LEVEL_W-1:0]            rsp_level_ff;

   // effective sizes
   logic [LEN_W-1:0]              len;
   logic [LEN_W-1:0]              len_m1;
   logic [CNT_W-1:0]              avg_cnt;
   logic [DVS_W-1:0]              avg_dvs;
   logic [CNT_W-1:0]              integ_cnt;

   logic signed [CMP_W-1:0]       min_raw;
   logic signed [CMP_W-1:0]       min_eff;
   logic signed [CMP_W-1:0]       s_ext;
   logic                          too_low;
   logic [LEN_W-1:0]              swi_p1;
   logic [IDX_W-1:0]              swi_next;
   logic                          filled_next;
   logic                          booting;
   logic [LEN_W-1:0]              dwi_p1;
   logic [IDX_W-1:0]              dwi_next;
   logic [IDX_W-1:0]              ptr_dec;

   logic signed [DIFF_W-1:0]      diff;
   logic [DIFF_W-1:0]             abs_diff;
   logic [DEV_W-1:0]              diff16;
   logic [2*DEV_W-1:0]            prod;
   logic [DEV_W-1:0]              sq;
   logic [DEV_W-1:0]              dev_term;
   logic [LEVEL_W:0]              sum_wide;
   logic [LEVEL_W-1:0]            sum_sat;
   logic [LEVEL_W:0]              smooth_wide;
   logic [LEVEL_W-1:0]            smooth_next;
   logic [LEVEL_W-1:0]            level_sel;
   logic [LEVEL_W-1:0]            level_out;

   // FSM outputs
   logic accept;
   logic issue;
   logic drained;
   logic load;

   always_comb begin
      len       = LEN_W'(clamp_len(int'(cfg.ring_length), RING_DEPTH));
      len_m1    = len - LEN_W'(1);
      avg_cnt   = CNT_W'(clamp_len(int'(cfg.average_length), AVERAGE_MAX));
      avg_dvs   = DVS_W'(clamp_len(int'(cfg.average_length), AVERAGE_MAX));
      integ_cnt = CNT_W'(clamp_len(int'(cfg.integrate_length), RING_DEPTH));
   end

   always_comb begin
      min_raw     = CMP_W'(cfg.rssi_floor);
      min_eff     = (min_raw > 0) ? '0 : min_raw;
      s_ext       = CMP_W'($signed(req_rssi_sample));
      too_low     = s_ext < min_eff;
      swi_p1      = LEN_W'(swi_ff) + LEN_W'(1);
      swi_next    = (swi_p1 == len) ? '0 : swi_p1[IDX_W-1:0];
      filled_next = filled_ff || (swi_next == '0);
      booting     = !filled_next && (int'(swi_next) < int'(avg_cnt));
      dwi_p1      = LEN_W'(dwi_ff) + LEN_W'(1);
      dwi_next    = (dwi_p1 == len) ? '0 : dwi_p1[IDX_W-1:0];
      ptr_dec     = (ptr_ff == '0) ? len_m1[IDX_W-1:0] : ptr_ff - IDX_W'(1);
   end

   // squared deviation from the mean, saturated to the ring width
   always_comb begin
      diff     = DIFF_W'(sample_ff) - DIFF_W'(div_rsp.quotient);
      abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      diff16   = DEV_W'(abs_diff);
      prod     = (2*DEV_W)'(diff16) * (2*DEV_W)'(diff16);
      sq       = ((abs_diff > DEV_MAX) || (prod > DEV_MAX)) ? DEV_MAX : prod[DEV_W-1:0];
   end

   always_comb begin
      dev_term    = dev_q_vld_ff ? dev_q_ff : '0;
      sum_wide    = {1'b0, sum_ff} + (LEVEL_W+1)'(dev_term);
      sum_sat     = (sum_wide > LEVEL_MAX) ? LEVEL_MAX : sum_wide[LEVEL_W-1:0];
      smooth_wide = {1'b0, sum_ff} + {1'b0, smooth_ff};
      smooth_next = smooth_wide[LEVEL_W:1];
      level_sel   = cfg.smoothing_enable ? smooth_next : sum_ff;
      level_out   = (cfg.threshold_enable && (level_sel < LEVEL_W'(cfg.alarm_threshold)))
                    ? '0 : level_sel;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (too_low || booting) ? S_EMIT : S_MEAN;
            end
         end
         S_MEAN:   if (drained) state_in = S_DIV;
         S_DIV:    if (div_rsp.done) state_in = S_SQR;
         S_SQR:    state_in = S_SUM;
         S_SUM:    if (drained) state_in = S_FINISH;
         S_FINISH: state_in = S_EMIT;
         S_EMIT:   if (load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      accept  = 1'b0;
      issue   = 1'b0;
      drained = 1'b0;
      load    = 1'b0;
      unique case (state_ff)
         S_IDLE: accept = req_valid;
         S_MEAN: begin
            issue   = cnt_ff < avg_cnt;
            drained = !issue && !rdv_ff;
         end
         S_SUM: begin
            issue   = cnt_ff < integ_cnt;
            drained = !issue && !rdv_ff;
         end
         S_EMIT:  load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign req_stall        = state_ff != S_IDLE;
   assign div_req.start    = (state_ff == S_MEAN) && drained;
   assign div_req.dividend = acc_ff;
   assign div_req.divisor  = avg_dvs;

   always_ff @(posedge clock) begin
      if (accept && !too_low) begin
         sample_mem[swi_ff] <= $signed(req_rssi_sample);
      end
      if ((state_ff == S_MEAN) && issue) begin
         sample_q_ff <= sample_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SQR) begin
         dev_mem[dwi_ff] <= sq;
      end
      if ((state_ff == S_SUM) && issue) begin
         dev_q_ff <= dev_mem[ptr_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         swi_ff       <= '0;
         dwi_ff       <= '0;
         filled_ff    <= 1'b0;
         smooth_ff    <= '0;
         dev_vld_ff   <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= issue;
         if (restart) begin
            swi_ff     <= '0;
            dwi_ff     <= '0;
            filled_ff  <= 1'b0;
            smooth_ff  <= '0;
            dev_vld_ff <= '0;
         end else begin
            if (accept && !too_low) begin
               swi_ff    <= swi_next;
               filled_ff <= filled_next;
            end
            if (state_ff == S_SQR) begin
               dev_vld_ff[dwi_ff] <= 1'b1;
            end
            if (state_ff == S_FINISH) begin
               smooth_ff <= smooth_next;
               dwi_ff    <= dwi_next;
            end
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= $signed(req_rssi_sample);
         ptr_ff    <= swi_ff;
         cnt_ff    <= '0;
         acc_ff    <= '0;
         if (too_low) begin
            res_status_ff <= ST_TOO_LOW;
         end else begin
            res_status_ff <= ST_BOOTING;
         end
         res_level_ff <= '0;
      end
      if (issue) begin
         ptr_ff <= ptr_dec;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if ((state_ff == S_MEAN) && rdv_ff) begin
         acc_ff <= acc_ff + ACC_W'(sample_q_ff);
      end
      if (state_ff == S_SQR) begin
         ptr_ff <= dwi_ff;
         cnt_ff <= '0;
         sum_ff <= '0;
      end
      if ((state_ff == S_SUM) && issue) begin
         dev_q_vld_ff <= dev_vld_ff[ptr_ff];
      end
      if ((state_ff == S_SUM) && rdv_ff) begin
         sum_ff <= sum_sat;
      end
      if (state_ff == S_FINISH) begin
         res_status_ff <= ST_VALID;
         res_level_ff  <= level_out;
      end
      if (load) begin
         rsp_status_ff <= res_status_ff;
         rsp_level_ff  <= res_level_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_level  = rsp_level_ff;

endmodule

@@ hdl/rmvd_checker.sv @@
module rmvd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [rmvd_pkg::LEVEL_W-1:0] rsp_level
);
   import rmvd_pkg::*;

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in work");

   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_VALID)) |-> (rsp_level == '0))
      else $error("non-valid status with a nonzero level");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_VALID) || (rsp_status == ST_BOOTING) ||
                     (rsp_status == ST_TOO_LOW)))
      else $error("undefined status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_level)))
      else $error("stalled result changed");

endmodule

bind rssi_moving_variance_detector rmvd_checker u_rmvd_checker (.*);

@@ sim/testbench.sv @@
module testbench;
   import rmvd_pkg::*;

   localparam int QUIET_LIMIT = 20000;

   // expected-result store and predictor of the detector
   class variance_scoreboard;
      logic [RL_W-1:0]                ring_length;
      logic [AL_W-1:0]                average_length;
      logic [IL_W-1:0]                integrate_length;
      logic [THR_W-1:0]               alarm_threshold;
      logic                           threshold_enable;
      logic                           smoothing_enable;
      logic signed [MIN_W-1:0]        rssi_floor;

      logic signed [SAMPLE_BITS-1:0]  sample_ring [RING_DEPTH];
      logic [DEV_W-1:0]               deviation_ring [RING_DEPTH];
      int unsigned                    sample_wr;
      int unsigned                    dev_wr;
      bit                             filled;
      logic [LEVEL_W-1:0]             smoothed;

      status_type                     exp_status [$];
      logic [LEVEL_W-1:0]             exp_level [$];
      int                             errors;
      int                             n_valid;
      int                             n_boot;
      int                             n_low;

      function new();
         errors  = 0;
         n_valid = 0;
         n_boot  = 0;
         n_low   = 0;
         power_on();
      endfunction

      function void restart();
         foreach (deviation_ring[i]) deviation_ring[i] = '0;
         sample_wr = 0;
         dev_wr    = 0;
         filled    = 0;
         smoothed  = '0;
      endfunction

      function void power_on();
         ring_length      = 256;
         average_length   = 64;
         integrate_length = 3;
         alarm_threshold  = 3;
         threshold_enable = 0;
         smoothing_enable = 0;
         rssi_floor       = -100;
         restart();
      endfunction

      function void write_reg(reg_index_type idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_RING_LENGTH: begin
               ring_length = value[RL_W-1:0];
               restart();
            end
            REG_AVERAGE_LENGTH:   average_length   = value[AL_W-1:0];
            REG_INTEGRATE_LENGTH: integrate_length = value[IL_W-1:0];
            REG_ALARM_THRESHOLD:  alarm_threshold  = value[THR_W-1:0];
            REG_THRESHOLD_ENABLE: threshold_enable = value[0];
            REG_SMOOTHING_ENABLE: smoothing_enable = value[0];
            REG_RSSI_FLOOR:       rssi_floor       = value[MIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int fit_len(int v, int hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function int pending();
         return exp_status.size();
      endfunction

      function void report(string what);
         errors++;
         if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
      endfunction

      function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
         int          len;
         int          avg;
         int          integ;
         int          minv;
         int          acc;
         int          mean;
         int          diff;
         int          pos;
         int unsigned sq;
         int unsigned sum;
         int unsigned lvl;
         len   = fit_len(ring_length, RING_DEPTH);
         avg   = fit_len(average_length, AVERAGE_MAX);
         integ = fit_len(integrate_length, RING_DEPTH);
         minv  = rssi_floor;
         if (minv > 0) minv = 0;
         if (int'(s) < minv) begin
            exp_status.push_back(ST_TOO_LOW);
            exp_level.push_back('0);
            return;
         end
         sample_ring[sample_wr] = s;
         sample_wr = (sample_wr + 1) % len;
         if (!filled && sample_wr == 0) filled = 1;
         if (!filled && sample_wr < avg) begin
            exp_status.push_back(ST_BOOTING);
            exp_level.push_back('0);
            return;
         end
         // newest avg samples, wrapping round a short ring
         acc = 0;
         pos = sample_wr;
         for (int i = 0; i < avg; i++) begin
            pos = (pos == 0) ? len - 1 : pos - 1;
            acc += sample_ring[pos];
         end
         mean = acc / avg;
         diff = int'(s) - mean;
         if (diff < 0) diff = -diff;
         sq = diff * diff;
         if (sq > 65535) sq = 65535;
         deviation_ring[dev_wr] = sq[DEV_W-1:0];
         sum = 0;
         pos = dev_wr;
         for (int i = 0; i < integ; i++) begin
            sum += deviation_ring[pos];
            if (sum > LEVEL_MAX) sum = LEVEL_MAX;
            pos = (pos == 0) ? len - 1 : pos - 1;
         end
         dev_wr = (dev_wr + 1) % len;
         smoothed = LEVEL_W'((sum + smoothed) / 2);
         lvl = smoothing_enable ? smoothed : sum;
         if (threshold_enable && lvl < alarm_threshold) lvl = 0;
         exp_status.push_back(ST_VALID);
         exp_level.push_back(LEVEL_W'(lvl));
      endfunction

      function void check_result(logic [1:0] got_status, logic [LEVEL_W-1:0] got_level);
         status_type         want_status;
         logic [LEVEL_W-1:0] want_level;
         if (exp_status.size() == 0) begin
            report($sformatf("result status %0d level %0d with nothing outstanding",
                             got_status, got_level));
            return;
         end
         want_status = exp_status.pop_front();
         want_level  = exp_level.pop_front();
         case (want_status)
            ST_VALID:   n_valid++;
            ST_BOOTING: n_boot++;
            default:    n_low++;
         endcase
         if (got_status !== want_status)
            report($sformatf("status %0d, expected %0d", got_status, want_status));
         if (got_level !== want_level)
            report($sformatf("level %0d, expected %0d", got_level, want_level));
      endfunction
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic [SAMPLE_BITS-1:0]   req_rssi_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic [1:0]               rsp_status;
   logic [LEVEL_W-1:0]       rsp_level;
   logic                     psel = 0;
   logic                     penable = 0;
   logic                     pwrite = 0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   variance_scoreboard sb = new();
   int  quiet_cycles = 0;
   int  n_writes = 0;
   bit  calm = 0;
   bit  motion = 0;
   int  eff_min = -100;
   int  base = -60;

   rssi_moving_variance_detector u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rssi_sample (req_rssi_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_level       (rsp_level),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #6 clock = ~clock;

   // handshakes are sampled here, with the values from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            sb.note_sample(req_rssi_sample);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_status, rsp_level);
            quiet_cycles = 0;
         end
         if (psel && penable && pready) quiet_cycles = 0;
      end
      rsp_stall <= !calm && ($urandom_range(99) < 10);
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("rssi_moving_variance_detector: mismatch");
      $finish;
   end

   task write_csr(input reg_index_type idx, input logic [DATA_W-1:0] value);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      sb.write_reg(idx, value);
      n_writes++;
      @(posedge clock);
   endtask

   task write_minimum(input int v);
      write_csr(REG_RSSI_FLOOR, 32'(v) & 32'h0000_00FF);
      eff_min = (v > 0) ? 0 : v;
   endtask

   task send_sample(input logic [SAMPLE_BITS-1:0] value);
      int gap;
      if (!calm && $urandom_range(99) < 10) begin
         gap = $urandom_range(1, 4);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1;
      req_rssi_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // every item yields a result, so an empty store means the block is idle
   task wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // quiet level with noise, now and then a burst of movement
   function automatic logic [SAMPLE_BITS-1:0] next_sample();
      int pick;
      int v;
      int spread;
      pick = $urandom_range(99);
      if (motion) begin
         if ($urandom_range(99) < 15) motion = 0;
      end else if ($urandom_range(99) < 5) begin
         motion = 1;
      end
      if (pick < 6) return SAMPLE_BITS'($urandom_range(255));
      if (pick < 11 && eff_min > -128) begin
         v = int'($urandom_range(eff_min + 127)) - 128;
         return SAMPLE_BITS'(v);
      end
      spread = motion ? 24 : 2;
      v = base + int'($urandom_range(2 * spread)) - spread;
      if (v < eff_min) v = eff_min;
      if (v > 127) v = 127;
      return SAMPLE_BITS'(v);
   endfunction

   task configure_phase();
      int v;
      if ($urandom_range(1)) begin
         case ($urandom_range(9))
            0:       v = 1;
            1:       v = 2;
            2:       v = 256;
            3:       v = 300;
            4:       v = 511;
            default: v = $urandom_range(3, 40);
         endcase
         write_csr(REG_RING_LENGTH, v);
      end
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(9))
            0:       v = 0;
            1:       v = 1;
            2:       v = 64;
            3:       v = 127;
            default: v = $urandom_range(2, 16);
         endcase
         write_csr(REG_AVERAGE_LENGTH, v);
      end
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(9))
            0:       v = 0;
            1:       v = 1;
            2:       v = 256;
            3:       v = 511;
            default: v = $urandom_range(2, 24);
         endcase
         write_csr(REG_INTEGRATE_LENGTH, v);
      end
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(4))
            0:       v = 0;
            1:       v = 65535;
            2:       v = $urandom_range(65535);
            default: v = $urandom_range(2000);
         endcase
         write_csr(REG_ALARM_THRESHOLD, v);
      end
      if ($urandom_range(3) != 0) write_csr(REG_THRESHOLD_ENABLE, $urandom_range(1));
      if ($urandom_range(3) != 0) write_csr(REG_SMOOTHING_ENABLE, $urandom_range(1));
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(5))
            0:       v = -128;
            1:       v = 0;
            2:       v = $urandom_range(1, 127);
            default: v = int'($urandom_range(60)) - 120;
         endcase
         write_minimum(v);
      end
      v = 127 - eff_min;
      base = eff_min + int'($urandom_range((v < 50) ? v : 50));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // register defaults: rejection below the minimum, then booting at and above it
      send_sample(8'h80);
      send_sample(-8'sd101);
      send_sample(-8'sd100);
      send_sample(8'h7F);
      wait_drained();

      // zero lengths act as one
      write_csr(REG_RING_LENGTH, 0);
      write_csr(REG_AVERAGE_LENGTH, 0);
      write_csr(REG_INTEGRATE_LENGTH, 0);
      write_minimum(-128);
      send_sample(8'h7F);
      send_sample(8'h80);
      send_sample(8'h00);
      wait_drained();

      // oversized lengths wrap round a short ring; threshold at its top
      write_csr(REG_RING_LENGTH, 3);
      write_csr(REG_AVERAGE_LENGTH, 127);
      write_csr(REG_INTEGRATE_LENGTH, 511);
      write_csr(REG_SMOOTHING_ENABLE, 1);
      write_csr(REG_THRESHOLD_ENABLE, 1);
      write_csr(REG_ALARM_THRESHOLD, 65535);
      send_sample(8'h7F);
      send_sample(8'h80);
      send_sample(8'h7F);
      send_sample(8'h80);
      wait_drained();

      // no restart: sizes change over a filled ring
      write_csr(REG_ALARM_THRESHOLD, 0);
      write_csr(REG_AVERAGE_LENGTH, 2);
      write_csr(REG_INTEGRATE_LENGTH, 2);
      write_csr(REG_SMOOTHING_ENABLE, 0);
      send_sample(8'h80);
      send_sample(8'h7F);
      send_sample(8'h80);
      send_sample(8'h7F);
      wait_drained();

      // a positive minimum behaves as zero
      write_minimum(5);
      write_csr(REG_THRESHOLD_ENABLE, 0);
      send_sample(8'hFF);
      send_sample(8'h00);
      send_sample(8'h01);
      send_sample(8'h7F);
      wait_drained();

      write_csr(REG_RING_LENGTH, 256);
      write_csr(REG_AVERAGE_LENGTH, 1);
      write_csr(REG_INTEGRATE_LENGTH, 1);
      write_minimum(0);
      send_sample(8'h7F);
      send_sample(8'h00);

      for (int p = 0; p < 10; p++) begin
         wait_drained();
         configure_phase();
         calm = (p == 4);
         repeat (110) send_sample(next_sample());
      end
      calm = 0;

      wait_drained();
      repeat (400) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

      $display("checked %0d results: %0d variance levels, %0d booting, %0d below minimum",
               sb.n_valid + sb.n_boot + sb.n_low, sb.n_valid, sb.n_boot, sb.n_low);
      $display("%0d register writes across ring, mean and sum lengths, threshold and IIR modes",
               n_writes);
      if (sb.errors == 0) begin
         $display("rssi_moving_variance_detector: match");
      end else begin
         $display("rssi_moving_variance_detector: mismatch");
      end
      $finish;
   end

endmodule

@@ rssi_moving_variance_detector.f @@
hdl/rmvd_pkg.sv
hdl/rmvd_csr.sv
hdl/rmvd_div.sv
hdl/rmvd_core.sv
hdl/rssi_moving_variance_detector.sv
hdl/rmvd_checker.sv
sim/testbench.sv
